FILE: design/byte_stuffed_frame_decoder_top_assert.svh
// assertion macros used by the frame decoder deframer module
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef BYTE_STUFFED_FRAME_DECODER_TOP_ASSERT_SVH
`define BYTE_STUFFED_FRAME_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("bsfd assertion failed");
// next-cycle implication
`define BSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("bsfd assertion failed");
`else
`define BSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/bsfd_pkg.sv
// types and constants of the byte stuffed frame decoder
// no dependencies
package bsfd_pkg;

	localparam int LengthBits = 16;
	localparam int StuffShift = 5;
	localparam int ByteBits   = 8;

	localparam logic [ByteBits-1:0] StuffMask = ByteBits'(1 << StuffShift);
	localparam logic [ByteBits-1:0] DelimReset = 8'd126;
	localparam logic [ByteBits-1:0] EscReset   = 8'd125;

	typedef enum logic [0:0] {
		CFG_START_DELIM = 1'b0,
		CFG_ESCAPE      = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_OUTSIDE = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_LEN_HI  = 5'b00010,
		PH_LEN_LO  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_TRAILER = 5'b10000
	} phase_t;

	// one decoded result, produced by the deframer for the result register
	typedef struct packed {
		logic                hit;
		kind_t               kind;
		logic [ByteBits-1:0] data;
		logic [15:0]         len;
	} res_t;

endpackage

FILE: design/bsfd_line_if.sv
// handshake interfaces for line bytes and decoded results
// no dependencies
interface bsfd_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink (input valid, input line_byte, output ready);
endinterface

interface bsfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  octet;
	logic [15:0] frame_length;

	modport source (output valid, output kind, output octet, output frame_length,
		input ready);
	modport sink (input valid, input kind, input octet, input frame_length,
		output ready);
endinterface

FILE: design/bsfd_in_reg.sv
// input register: holds one line byte until the deframer takes it
// depends on bsfd_pkg and bsfd_line_if
module bsfd_in_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	bsfd_line_if.sink                    line_ch,
	input  logic                         take,
	output logic                         valid_s1,
	output logic [bsfd_pkg::ByteBits-1:0] byte_s1
);
	import bsfd_pkg::*;

	logic vld_s1;

	assign line_ch.ready = !vld_s1 || take;
	assign valid_s1      = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (line_ch.ready) begin
			vld_s1 <= line_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ch.ready && line_ch.valid) begin
			byte_s1 <= line_ch.line_byte;
		end
	end

endmodule

FILE: design/bsfd_deframe.sv
// deframer: configuration, frame state and the per-byte decode
// depends on bsfd_pkg and the assertion header
`include "byte_stuffed_frame_decoder_top_assert.svh"

module bsfd_deframe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          step,
	input  logic [bsfd_pkg::ByteBits-1:0] byte_s1,
	output bsfd_pkg::res_t                res
);
	import bsfd_pkg::*;

	logic [ByteBits-1:0]   delim_q, esc_byte_q;
	phase_t                phase_q, phase_d;
	logic                  esc_q, esc_d;
	logic [ByteBits-1:0]   len_hi_q, len_hi_d;
	logic [LengthBits-1:0] total_q, total_d;
	logic [LengthBits-1:0] remain_q, remain_d;
	logic [ByteBits-1:0]   b;
	logic                  have;
	phase_t                hunt_phase;
	res_t                  hunt_res;
	logic [LengthBits-1:0] new_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q    <= DelimReset;
			esc_byte_q <= EscReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_DELIM: delim_q <= cfg_wdata;
				CFG_ESCAPE:      esc_byte_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// unstuffing ahead of the phase decode
	always_comb begin
		if (esc_q) begin
			b    = byte_s1 ^ StuffMask;
			have = 1'b1;
		end else if (byte_s1 == esc_byte_q) begin
			b    = byte_s1;
			have = 1'b0;
		end else begin
			b    = byte_s1;
			have = 1'b1;
		end
	end

	assign new_total = LengthBits'({len_hi_q, b});

	always_comb begin
		hunt_res      = '0;
		hunt_res.data = byte_s1;
		if (byte_s1 == delim_q) begin
			hunt_phase = PH_LEN_HI;
		end else begin
			hunt_phase    = PH_HUNT;
			hunt_res.hit  = 1'b1;
			hunt_res.kind = KIND_OUTSIDE;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		esc_d    = 1'b0;
		len_hi_d = len_hi_q;
		total_d  = total_q;
		remain_d = remain_q;
		res      = '0;
		res.data = b;
		unique case (phase_q)
			PH_LEN_HI: begin
				esc_d = !esc_q && !have;
				if (have) begin
					len_hi_d = b;
					phase_d  = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				esc_d = !esc_q && !have;
				if (have) begin
					total_d  = new_total;
					remain_d = new_total;
					phase_d  = (new_total == '0) ? PH_TRAILER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				esc_d = !esc_q && !have;
				if (have) begin
					remain_d = remain_q - LengthBits'(1);
					if (remain_q == LengthBits'(1)) begin
						phase_d = PH_TRAILER;
					end
					res.hit  = 1'b1;
					res.kind = KIND_PAYLOAD;
				end
			end
			PH_TRAILER: begin
				esc_d = !esc_q && !have;
				if (have) begin
					phase_d  = PH_HUNT;
					res.hit  = 1'b1;
					res.kind = (b == '0) ? KIND_GOOD : KIND_BAD;
					res.len  = 16'(total_q);
				end
			end
			default: begin
				// hunt, and any stray code behaves as hunt
				phase_d = hunt_phase;
				res     = hunt_res;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			esc_q    <= 1'b0;
			len_hi_q <= '0;
			total_q  <= '0;
			remain_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			esc_q    <= esc_d;
			len_hi_q <= len_hi_d;
			total_q  <= total_d;
			remain_q <= remain_d;
		end
	end

	`BSFD_ASSERT_IMPL(a_esc_only_in_frame, clk, arst_n, esc_q, phase_q != PH_HUNT)
	`BSFD_ASSERT_IMPL(a_payload_count_live, clk, arst_n, phase_q == PH_PAYLOAD,
		remain_q != '0)
	`BSFD_ASSERT_NEXT(a_frame_end_hunts, clk, arst_n,
		step && res.hit && (res.kind == KIND_GOOD || res.kind == KIND_BAD),
		phase_q == PH_HUNT && !esc_q)

endmodule

FILE: design/bsfd_out_reg.sv
// result register: holds one decoded beat for the result channel
// depends on bsfd_pkg and bsfd_result_if
module bsfd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  bsfd_pkg::res_t res,
	output logic           take,
	bsfd_result_if.source  result_ch
);
	import bsfd_pkg::*;

	logic  vld_s2;
	res_t  res_s2;

	// a byte leaves the input register once the result slot is free
	assign take = valid_s1 && (!vld_s2 || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (take) begin
			vld_s2 <= res.hit;
		end else if (result_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

	assign result_ch.valid        = vld_s2;
	assign result_ch.kind         = res_s2.kind;
	assign result_ch.octet        = res_s2.data;
	assign result_ch.frame_length = res_s2.len;

endmodule

FILE: design/byte_stuffed_frame_decoder_top.sv
// channel     dir   beat contents
// line_ch     in    line_byte (8 bit raw link byte)
// result_ch   out   kind (2), octet (8), frame_length (16)
// cfg_*       in    write enable, register index, 8 bit data
//
// one line byte per cycle unless the result channel stalls: input register, decode, result register
// an accepted byte is held in the input register, then its result beat in the result register
// bytes that give no result (delimiter, escape, header) still pass the decode stage
// a stalled result holds the decode stage; reset returns to hunting with
// delimiter 0x7e and escape 0x7d
// depends on bsfd_pkg, the channel interfaces, bsfd_in_reg, bsfd_deframe, bsfd_out_reg
module byte_stuffed_frame_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	bsfd_line_if.sink     line_ch,
	bsfd_result_if.source result_ch,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_wdata
);
	import bsfd_pkg::*;

	logic                valid_s1;
	logic [ByteBits-1:0] byte_s1;
	logic                take;
	res_t                res;

	bsfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.line_ch  (line_ch),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	bsfd_deframe u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (take),
		.byte_s1   (byte_s1),
		.res       (res)
	);

	bsfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.take      (take),
		.result_ch (result_ch)
	);

endmodule
